// ===== rtl/psalu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Packed SIMD ALU package
// Shared constants, operation and lane codes, state and control types.
// ----------------------------------------------------------------------------
package psalu_pkg;

    localparam int VREG_COUNT  = 16;
    localparam int VREG_IDX_W  = $clog2(VREG_COUNT);
    localparam int INDEX_W     = 8;
    localparam int OP_W        = 4;
    localparam int LANE_CODE_W = 2;
    localparam int HALF_W      = 64;
    localparam int VEC_W       = 2 * HALF_W;
    localparam int BYTE_COUNT  = VEC_W / 8;
    localparam int BYTE_IDX_W  = $clog2(BYTE_COUNT);
    localparam int BIT_IDX_W   = $clog2(VEC_W);
    localparam int EXT_W       = BYTE_COUNT * 9;
    localparam int MUL_CNT_W   = 7;

    typedef logic [VEC_W-1:0] vec_t;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 4'd0,
        OP_READ = 4'd1,
        OP_MOVE = 4'd2,
        OP_ADD  = 4'd3,
        OP_SUB  = 4'd4,
        OP_MUL  = 4'd5,
        OP_AND  = 4'd6,
        OP_OR   = 4'd7,
        OP_XOR  = 4'd8
    } op_t;

    typedef enum logic [LANE_CODE_W-1:0] {
        LANE_8  = 2'd0,
        LANE_16 = 2'd1,
        LANE_32 = 2'd2,
        LANE_64 = 2'd3
    } lane_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MUL
    } state_t;

    typedef struct packed {
        logic take;
        logic mul_load;
        logic mul_step;
        logic finish;
    } psalu_cmd_t;

    typedef struct packed {
        logic mul_op;
        logic mul_done;
        logic out_stall;
    } psalu_sts_t;

endpackage
`default_nettype wire

// ===== rtl/psalu_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Packed SIMD ALU channel interfaces
// Instruction and result channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface psalu_instr_if
    import psalu_pkg::*;
    ;
    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        operation;
    logic [LANE_CODE_W-1:0] lane_size;
    logic [INDEX_W-1:0]     dest_index;
    logic [INDEX_W-1:0]     left_index;
    logic [INDEX_W-1:0]     right_index;
    logic [HALF_W-1:0]      load_low;
    logic [HALF_W-1:0]      load_high;

    modport source (
        output valid, operation, lane_size, dest_index, left_index, right_index,
               load_low, load_high,
        input  ready
    );

    modport sink (
        input  valid, operation, lane_size, dest_index, left_index, right_index,
               load_low, load_high,
        output ready
    );
endinterface

interface psalu_result_if
    import psalu_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] value_low;
    logic [HALF_W-1:0] value_high;
    logic              illegal_register;

    modport source (
        output valid, value_low, value_high, illegal_register,
        input  ready
    );

    modport sink (
        input  valid, value_low, value_high, illegal_register,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/packed_simd_integer_alu_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Packed SIMD integer ALU
// A file of sixteen 128-bit vector registers with lane-wise add, subtract
// and multiply on 8/16/32/64-bit lanes, bitwise logic, load, read and move.
//
// The instr channel takes one instruction per beat; the result channel
// returns exactly one beat per instruction, in order, carrying the
// destination's new value (or the value read) and an illegal-index flag.
// Load, read, move, add, subtract and the logic operations are accepted
// while the register file is read into registers; the execute state then
// computes, writes back and fills the output register. Only then is a new
// instruction accepted, so none is taken before the last one has executed.
// Multiply runs a shift-add loop over the lane width, one bit per cycle,
// between a load step and the write-back.
// The output register lets the next instruction be accepted while a result
// waits; if the receiver stalls, execution of the following instruction
// holds until the output register frees up.
// Reset clears every vector register to zero through per-entry valid bits,
// empties the output register and returns the controller to idle.
// ----------------------------------------------------------------------------
module packed_simd_integer_alu_unit
    import psalu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    psalu_instr_if.sink    instr,
    psalu_result_if.source result
);

    psalu_cmd_t cmd;
    psalu_sts_t sts;

    psalu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (instr.valid),
        .in_ready (instr.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    psalu_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .operation        (instr.operation),
        .lane_size        (instr.lane_size),
        .dest_index       (instr.dest_index),
        .left_index       (instr.left_index),
        .right_index      (instr.right_index),
        .load_low         (instr.load_low),
        .load_high        (instr.load_high),
        .out_valid        (result.valid),
        .out_ready        (result.ready),
        .value_low        (result.value_low),
        .value_high       (result.value_high),
        .illegal_register (result.illegal_register)
    );

endmodule
`default_nettype wire

// ===== rtl/psalu_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Packed SIMD ALU controller
// Sequences accept, execute, multiply steps and result hand-off.
// ----------------------------------------------------------------------------
module psalu_ctrl
    import psalu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire psalu_sts_t sts,
    output psalu_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.mul_op)
                begin
                    state_next = S_MUL;
                end
                else if (!sts.out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MUL:
            begin
                if (sts.mul_done && !sts.out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            S_EXEC:
            begin
                if (sts.mul_op)
                begin
                    cmd.mul_load = 1'b1;
                end
                else
                begin
                    cmd.finish = !sts.out_stall;
                end
            end
            S_MUL:
            begin
                if (!sts.mul_done)
                begin
                    cmd.mul_step = 1'b1;
                end
                else
                begin
                    cmd.finish = !sts.out_stall;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/psalu_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Packed SIMD ALU datapath
// Vector register file, lane-segmented adder, shift-add multiplier and
// the output register.
// ----------------------------------------------------------------------------
module psalu_dp
    import psalu_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire psalu_cmd_t             cmd,
    output psalu_sts_t                  sts,
    input  wire logic [OP_W-1:0]        operation,
    input  wire logic [LANE_CODE_W-1:0] lane_size,
    input  wire logic [INDEX_W-1:0]     dest_index,
    input  wire logic [INDEX_W-1:0]     left_index,
    input  wire logic [INDEX_W-1:0]     right_index,
    input  wire logic [HALF_W-1:0]      load_low,
    input  wire logic [HALF_W-1:0]      load_high,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [HALF_W-1:0]           value_low,
    output logic [HALF_W-1:0]           value_high,
    output logic                        illegal_register
);

    function automatic logic lane_first(logic [LANE_CODE_W-1:0] ls,
                                        logic [BYTE_IDX_W-1:0] j);
        logic r;
        case (ls)
            LANE_8:  r = 1'b1;
            LANE_16: r = (j[0] == 1'b0);
            LANE_32: r = (j[1:0] == 2'b00);
            LANE_64: r = (j[2:0] == 3'b000);
            default: r = 1'b1;
        endcase
        return r;
    endfunction

    function automatic logic lane_last(logic [LANE_CODE_W-1:0] ls,
                                       logic [BYTE_IDX_W-1:0] j);
        logic r;
        case (ls)
            LANE_8:  r = 1'b1;
            LANE_16: r = j[0];
            LANE_32: r = &j[1:0];
            LANE_64: r = &j[2:0];
            default: r = 1'b1;
        endcase
        return r;
    endfunction

    function automatic logic [BYTE_IDX_W-1:0] lane_low_mask(logic [LANE_CODE_W-1:0] ls);
        logic [BYTE_IDX_W-1:0] r;
        case (ls)
            LANE_8:  r = BYTE_IDX_W'(0);
            LANE_16: r = BYTE_IDX_W'(1);
            LANE_32: r = BYTE_IDX_W'(3);
            LANE_64: r = BYTE_IDX_W'(7);
            default: r = BYTE_IDX_W'(0);
        endcase
        return r;
    endfunction

    function automatic logic [MUL_CNT_W-1:0] lane_bits(logic [LANE_CODE_W-1:0] ls);
        logic [MUL_CNT_W-1:0] r;
        case (ls)
            LANE_8:  r = MUL_CNT_W'(8);
            LANE_16: r = MUL_CNT_W'(16);
            LANE_32: r = MUL_CNT_W'(32);
            LANE_64: r = MUL_CNT_W'(64);
            default: r = MUL_CNT_W'(8);
        endcase
        return r;
    endfunction

    // A spacer bit sits between bytes. At a lane boundary it absorbs the
    // carry out (add) or injects the lane's carry in (subtract); inside a
    // lane it passes the carry along.
    function automatic vec_t seg_add(vec_t a, vec_t b, logic [LANE_CODE_W-1:0] ls,
                                     logic sub);
        logic [EXT_W-1:0] xa;
        logic [EXT_W-1:0] xb;
        logic [EXT_W-1:0] xs;
        vec_t             bb;
        vec_t             r;
        logic             brk;
        bb = sub ? ~b : b;
        for (int j = 0; j < BYTE_COUNT; j++)
        begin
            if (j == BYTE_COUNT - 1)
            begin
                brk = 1'b1;
            end
            else
            begin
                brk = lane_first(ls, BYTE_IDX_W'(j + 1));
            end
            xa[9*j +: 8] = a[8*j +: 8];
            xb[9*j +: 8] = bb[8*j +: 8];
            xa[9*j + 8]  = sub | ~brk;
            xb[9*j + 8]  = sub & brk;
        end
        xs = xa + xb + EXT_W'(sub);
        for (int j = 0; j < BYTE_COUNT; j++)
        begin
            r[8*j +: 8] = xs[9*j +: 8];
        end
        return r;
    endfunction

    function automatic vec_t lane_bcast(vec_t m, logic [LANE_CODE_W-1:0] ls);
        vec_t                  r;
        logic [BYTE_IDX_W-1:0] base;
        for (int j = 0; j < BYTE_COUNT; j++)
        begin
            base        = BYTE_IDX_W'(j) & ~lane_low_mask(ls);
            r[8*j +: 8] = {8{m[BIT_IDX_W'({base, 3'b000})]}};
        end
        return r;
    endfunction

    function automatic logic idx_bad(logic [INDEX_W-1:0] i);
        return i >= INDEX_W'(VREG_COUNT);
    endfunction

    // Register file and its per-entry valid bits.
    vec_t                   mem [VREG_COUNT];
    logic [VREG_COUNT-1:0]  vld_reg;
    vec_t                   a_raw_reg;
    vec_t                   b_raw_reg;
    logic                   a_vld_reg;
    logic                   b_vld_reg;

    // Latched item.
    logic [OP_W-1:0]        op_reg;
    logic [LANE_CODE_W-1:0] lane_reg;
    logic [VREG_IDX_W-1:0]  dest_reg;
    logic [HALF_W-1:0]      load_lo_reg;
    logic [HALF_W-1:0]      load_hi_reg;
    logic                   illegal_reg;

    // Multiplier.
    vec_t                   mcand_reg;
    vec_t                   mplier_reg;
    vec_t                   acc_reg;
    logic [MUL_CNT_W-1:0]   cnt_reg;

    // Output register.
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [HALF_W-1:0]      out_lo_reg;
    logic [HALF_W-1:0]      out_hi_reg;
    logic                   out_ill_reg;

    logic                   illegal_in;
    logic [VREG_IDX_W-1:0]  rd_a_addr;
    logic [VREG_IDX_W-1:0]  rd_b_addr;
    logic [VREG_IDX_W-1:0]  wr_addr;
    vec_t                   a_vec;
    vec_t                   b_vec;
    vec_t                   res;
    vec_t                   start_mask;
    vec_t                   top_mask;
    logic                   wr_en;

    always_comb
    begin
        if (operation inside {OP_LOAD, OP_READ})
        begin
            illegal_in = idx_bad(dest_index);
        end
        else if (operation == OP_MOVE)
        begin
            illegal_in = idx_bad(dest_index) | idx_bad(left_index);
        end
        else if (operation inside {[OP_ADD:OP_XOR]})
        begin
            illegal_in = idx_bad(dest_index) | idx_bad(left_index) | idx_bad(right_index);
        end
        else
        begin
            illegal_in = 1'b0;
        end
    end

    assign rd_a_addr = (operation == OP_READ) ? dest_index[VREG_IDX_W-1:0]
                                              : left_index[VREG_IDX_W-1:0];
    assign rd_b_addr = right_index[VREG_IDX_W-1:0];
    assign wr_addr   = dest_reg;

    assign a_vec = a_vld_reg ? a_raw_reg : '0;
    assign b_vec = b_vld_reg ? b_raw_reg : '0;

    always_comb
    begin
        for (int j = 0; j < BYTE_COUNT; j++)
        begin
            start_mask[8*j +: 8] = {7'b0, lane_first(lane_reg, BYTE_IDX_W'(j))};
            top_mask[8*j +: 8]   = {lane_last(lane_reg, BYTE_IDX_W'(j)), 7'b0};
        end
    end

    always_comb
    begin
        case (op_reg)
            OP_LOAD: res = {load_hi_reg, load_lo_reg};
            OP_READ: res = a_vec;
            OP_MOVE: res = a_vec;
            OP_ADD:  res = seg_add(a_vec, b_vec, lane_reg, 1'b0);
            OP_SUB:  res = seg_add(a_vec, b_vec, lane_reg, 1'b1);
            OP_MUL:  res = acc_reg;
            OP_AND:  res = a_vec & b_vec;
            OP_OR:   res = a_vec | b_vec;
            OP_XOR:  res = a_vec ^ b_vec;
            default: res = '0;
        endcase
        if (illegal_reg)
        begin
            res = '0;
        end
    end

    assign wr_en = cmd.finish && !illegal_reg &&
                   (op_reg inside {OP_LOAD, OP_MOVE, OP_ADD, OP_SUB, OP_MUL,
                                   OP_AND, OP_OR, OP_XOR});

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= res;
        end
        if (cmd.take)
        begin
            a_raw_reg <= mem[rd_a_addr];
            b_raw_reg <= mem[rd_b_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (cmd.take)
            begin
                a_vld_reg <= vld_reg[rd_a_addr];
                b_vld_reg <= vld_reg[rd_b_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg      <= operation;
            lane_reg    <= lane_size;
            dest_reg    <= dest_index[VREG_IDX_W-1:0];
            load_lo_reg <= load_low;
            load_hi_reg <= load_high;
            illegal_reg <= illegal_in;
        end
    end

    // Shift-add multiply, one multiplier bit per lane each step.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            mcand_reg  <= a_vec;
            mplier_reg <= b_vec;
            acc_reg    <= '0;
        end
        else if (cmd.mul_step)
        begin
            acc_reg    <= seg_add(acc_reg, mcand_reg & lane_bcast(mplier_reg, lane_reg),
                                  lane_reg, 1'b0);
            mcand_reg  <= (mcand_reg << 1) & ~start_mask;
            mplier_reg <= (mplier_reg >> 1) & ~top_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.mul_load)
        begin
            cnt_reg <= lane_bits(lane_reg);
        end
        else if (cmd.mul_step)
        begin
            cnt_reg <= cnt_reg - MUL_CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_lo_reg  <= res[HALF_W-1:0];
            out_hi_reg  <= res[VEC_W-1:HALF_W];
            out_ill_reg <= illegal_reg;
        end
    end

    assign sts.mul_op    = (op_reg == OP_MUL) && !illegal_reg;
    assign sts.mul_done  = (cnt_reg == '0);
    assign sts.out_stall = out_valid_reg && !out_ready;

    assign out_valid        = out_valid_reg;
    assign value_low        = out_lo_reg;
    assign value_high       = out_hi_reg;
    assign illegal_register = out_ill_reg;

endmodule
`default_nettype wire

// ===== rtl/psalu_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Packed SIMD ALU port checker
// Watches the top-level channels and flags ordering and payload slips.
// ----------------------------------------------------------------------------
module psalu_chk
    import psalu_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [HALF_W-1:0] value_low,
    input wire logic [HALF_W-1:0] value_high,
    input wire logic              illegal_register
);

    // Only one instruction is executing at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("instruction accepted while another was executing");

    // A result only appears after an instruction has been executing.
    a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without an instruction in execution");

    // An illegal index always returns a zero value.
    a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && illegal_register |-> value_low == '0 && value_high == '0)
        else $error("illegal result carries a nonzero value");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_low) &&
            $stable(value_high) && $stable(illegal_register))
        else $error("stalled result beat changed");

endmodule

bind packed_simd_integer_alu_unit psalu_chk u_psalu_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (instr.valid),
    .in_ready         (instr.ready),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .value_low        (result.value_low),
    .value_high       (result.value_high),
    .illegal_register (result.illegal_register)
);
`default_nettype wire

// ===== sim/tb_packed_simd_integer_alu_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Packed SIMD integer ALU testbench
// Drives instruction beats through a directed table and then random
// instruction streams. A shadow vector register file predicts each result
// beat the table leaves open; results are checked in order, field by field.
// Both channels idle and stall at random, with one long stretch at full rate.
// ----------------------------------------------------------------------------
module tb_packed_simd_integer_alu_unit;
    import psalu_pkg::*;

    localparam int CYCLE_LIMIT    = 700000;
    localparam int RANDOM_COUNT   = 1350;
    localparam int STEADY_FIRST   = 500;
    localparam int STEADY_LAST    = 800;
    localparam int DRAIN_CYCLES   = 100;
    localparam int IDLE_PERCENT   = 11;
    localparam int REPORT_LIMIT   = 10;
    localparam int DIRECTED_COUNT = 25;

    localparam logic [OP_W-1:0]    OP_UNDEF_FIRST = 4'd9;
    localparam logic [OP_W-1:0]    OP_UNDEF_LAST  = 4'd15;
    localparam logic [INDEX_W-1:0] BAD_INDEX_LOW  = INDEX_W'(VREG_COUNT);
    localparam logic [INDEX_W-1:0] BAD_INDEX_HIGH = 8'hFF;
    localparam logic [INDEX_W-1:0] LAST_INDEX     = INDEX_W'(VREG_COUNT - 1);
    localparam logic [HALF_W-1:0]  ALL_ONES       = {HALF_W{1'b1}};
    localparam logic [HALF_W-1:0]  SIGN_BYTES     = {8{8'h80}};
    localparam logic [HALF_W-1:0]  MAX_BYTES      = {8{8'h7F}};
    localparam logic [HALF_W-1:0]  RAMP_LOW       = 64'h0123_4567_89AB_CDEF;
    localparam logic [HALF_W-1:0]  RAMP_HIGH      = 64'hFEDC_BA98_7654_3210;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        lane_t              lane_size;
        logic [INDEX_W-1:0] dest_index;
        logic [INDEX_W-1:0] left_index;
        logic [INDEX_W-1:0] right_index;
        logic [HALF_W-1:0]  load_low;
        logic [HALF_W-1:0]  load_high;
    } vec_instr_t;

    typedef struct packed {
        logic [HALF_W-1:0] value_low;
        logic [HALF_W-1:0] value_high;
        logic              illegal_register;
    } vec_result_t;

    typedef struct packed {
        vec_instr_t  instr;
        logic        fixed;
        vec_result_t fixed_result;
    } directed_row_t;

    localparam vec_result_t ZERO_RESULT    = '0;
    localparam vec_result_t ILLEGAL_RESULT = '{'0, '0, 1'b1};

    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{'{OP_READ, LANE_8, 8'd0, 8'd0, 8'd0, '0, '0}, 1'b1, ZERO_RESULT},
        '{'{OP_READ, LANE_64, LAST_INDEX, 8'd0, 8'd0, '0, '0}, 1'b1, ZERO_RESULT},
        '{'{OP_LOAD, LANE_8, LAST_INDEX, 8'd0, 8'd0, ALL_ONES, ALL_ONES},
          1'b1, '{ALL_ONES, ALL_ONES, 1'b0}},
        '{'{OP_LOAD, LANE_64, 8'd0, BAD_INDEX_HIGH, BAD_INDEX_HIGH, '0, '0},
          1'b1, ZERO_RESULT},
        '{'{OP_LOAD, LANE_16, 8'd1, 8'd0, 8'd0, SIGN_BYTES, MAX_BYTES},
          1'b1, '{SIGN_BYTES, MAX_BYTES, 1'b0}},
        '{'{OP_LOAD, LANE_32, 8'd2, 8'd0, 8'd0, RAMP_LOW, RAMP_HIGH},
          1'b1, '{RAMP_LOW, RAMP_HIGH, 1'b0}},
        '{'{OP_READ, LANE_8, BAD_INDEX_LOW, 8'd0, 8'd0, '0, '0}, 1'b1, ILLEGAL_RESULT},
        '{'{OP_LOAD, LANE_8, BAD_INDEX_HIGH, 8'd0, 8'd0, ALL_ONES, ALL_ONES},
          1'b1, ILLEGAL_RESULT},
        '{'{OP_MOVE, LANE_8, 8'd3, BAD_INDEX_LOW, 8'd0, '0, '0}, 1'b1, ILLEGAL_RESULT},
        '{'{OP_ADD, LANE_8, 8'd3, 8'd1, BAD_INDEX_HIGH, '0, '0}, 1'b1, ILLEGAL_RESULT},
        '{'{OP_UNDEF_FIRST, LANE_8, 8'd3, 8'd1, 8'd2, ALL_ONES, ALL_ONES},
          1'b1, ZERO_RESULT},
        '{'{OP_UNDEF_LAST, LANE_64, BAD_INDEX_HIGH, BAD_INDEX_HIGH, BAD_INDEX_HIGH,
            ALL_ONES, ALL_ONES}, 1'b1, ZERO_RESULT},
        '{'{OP_READ, LANE_64, 8'd2, BAD_INDEX_HIGH, BAD_INDEX_HIGH, '0, '0},
          1'b0, ZERO_RESULT},
        '{'{OP_MOVE, LANE_8, 8'd3, LAST_INDEX, BAD_INDEX_HIGH, '0, '0}, 1'b0, ZERO_RESULT},
        '{'{OP_ADD, LANE_8, 8'd4, 8'd1, LAST_INDEX, '0, '0}, 1'b0, ZERO_RESULT},
        '{'{OP_ADD, LANE_16, 8'd5, 8'd2, LAST_INDEX, '0, '0}, 1'b0, ZERO_RESULT},
        '{'{OP_ADD, LANE_32, 8'd6, LAST_INDEX, LAST_INDEX, '0, '0}, 1'b0, ZERO_RESULT},
        '{'{OP_ADD, LANE_64, 8'd7, 8'd1, 8'd1, '0, '0}, 1'b0, ZERO_RESULT},
        '{'{OP_SUB, LANE_8, 8'd8, 8'd0, LAST_INDEX, '0, '0}, 1'b0, ZERO_RESULT},
        '{'{OP_SUB, LANE_64, 8'd9, 8'd0, 8'd2, '0, '0}, 1'b0, ZERO_RESULT},
        '{'{OP_MUL, LANE_8, 8'd10, 8'd2, 8'd1, '0, '0}, 1'b0, ZERO_RESULT},
        '{'{OP_MUL, LANE_64, 8'd11, LAST_INDEX, 8'd2, '0, '0}, 1'b0, ZERO_RESULT},
        '{'{OP_AND, LANE_8, 8'd12, 8'd1, 8'd2, '0, '0}, 1'b0, ZERO_RESULT},
        '{'{OP_OR, LANE_16, 8'd13, 8'd1, 8'd2, '0, '0}, 1'b0, ZERO_RESULT},
        '{'{OP_XOR, LANE_32, 8'd3, 8'd3, 8'd2, '0, '0}, 1'b0, ZERO_RESULT}
    };

    logic clk;
    logic rst_n;
    logic idle_enabled;
    int   cycle_count;
    int   mismatch_count;

    logic [HALF_W-1:0] shadow_low  [VREG_COUNT];
    logic [HALF_W-1:0] shadow_high [VREG_COUNT];
    vec_result_t       pending_results [$];

    psalu_instr_if  instr_bus ();
    psalu_result_if result_bus ();

    packed_simd_integer_alu_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_bus),
        .result (result_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [HALF_W-1:0] lane_combine(input logic [HALF_W-1:0] a,
                                                       input logic [HALF_W-1:0] b,
                                                       input lane_t lane,
                                                       input logic [OP_W-1:0] op);
        int                width;
        int                sh;
        logic [HALF_W-1:0] mask;
        logic [HALF_W-1:0] x;
        logic [HALF_W-1:0] y;
        logic [HALF_W-1:0] r;
        logic [HALF_W-1:0] acc;
        width = 8 << lane;
        mask  = (width >= HALF_W) ? ALL_ONES : ((64'd1 << width) - 64'd1);
        acc   = '0;
        for (sh = 0; sh < HALF_W; sh += width)
        begin
            x = (a >> sh) & mask;
            y = (b >> sh) & mask;
            if (op == OP_ADD)
                r = x + y;
            else if (op == OP_SUB)
                r = x - y;
            else
                r = x * y;
            acc |= (r & mask) << sh;
        end
        return acc;
    endfunction

    function automatic vec_result_t execute_instruction(input vec_instr_t ins);
        vec_result_t             res;
        logic                    usable;
        logic [VREG_IDX_W-1:0]   d;
        logic [VREG_IDX_W-1:0]   l;
        logic [VREG_IDX_W-1:0]   r;
        res = '0;
        if (ins.operation > OP_XOR)
            return res;
        case (ins.operation)
            OP_LOAD, OP_READ: usable = ins.dest_index < VREG_COUNT;
            OP_MOVE:          usable = ins.dest_index < VREG_COUNT
                                       && ins.left_index < VREG_COUNT;
            default:          usable = ins.dest_index < VREG_COUNT
                                       && ins.left_index < VREG_COUNT
                                       && ins.right_index < VREG_COUNT;
        endcase
        if (!usable)
        begin
            res.illegal_register = 1'b1;
            return res;
        end
        d = ins.dest_index[VREG_IDX_W-1:0];
        l = ins.left_index[VREG_IDX_W-1:0];
        r = ins.right_index[VREG_IDX_W-1:0];
        case (ins.operation)
            OP_LOAD:
            begin
                res.value_low  = ins.load_low;
                res.value_high = ins.load_high;
            end
            OP_READ:
            begin
                res.value_low  = shadow_low[d];
                res.value_high = shadow_high[d];
            end
            OP_MOVE:
            begin
                res.value_low  = shadow_low[l];
                res.value_high = shadow_high[l];
            end
            OP_AND:
            begin
                res.value_low  = shadow_low[l] & shadow_low[r];
                res.value_high = shadow_high[l] & shadow_high[r];
            end
            OP_OR:
            begin
                res.value_low  = shadow_low[l] | shadow_low[r];
                res.value_high = shadow_high[l] | shadow_high[r];
            end
            OP_XOR:
            begin
                res.value_low  = shadow_low[l] ^ shadow_low[r];
                res.value_high = shadow_high[l] ^ shadow_high[r];
            end
            default:
            begin
                res.value_low  = lane_combine(shadow_low[l], shadow_low[r],
                                              ins.lane_size, ins.operation);
                res.value_high = lane_combine(shadow_high[l], shadow_high[r],
                                              ins.lane_size, ins.operation);
            end
        endcase
        if (ins.operation != OP_READ)
        begin
            shadow_low[d]  = res.value_low;
            shadow_high[d] = res.value_high;
        end
        return res;
    endfunction

    function automatic logic [INDEX_W-1:0] random_index();
        if ($urandom_range(99) < 8)
            return INDEX_W'($urandom_range(255, VREG_COUNT));
        return INDEX_W'($urandom_range(VREG_COUNT - 1));
    endfunction

    function automatic logic [HALF_W-1:0] random_half();
        case ($urandom_range(5))
            0:       return ALL_ONES;
            1:       return '0;
            2:       return ($urandom_range(1) != 0) ? SIGN_BYTES : MAX_BYTES;
            3:       return HALF_W'($urandom_range(255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic vec_instr_t random_instruction();
        vec_instr_t ins;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 5)
            ins.operation = OP_W'($urandom_range(OP_UNDEF_LAST, OP_UNDEF_FIRST));
        else if (pick < 27)
            ins.operation = OP_LOAD;
        else
            ins.operation = OP_W'($urandom_range(OP_XOR, OP_READ));
        ins.lane_size   = lane_t'($urandom_range(3));
        ins.dest_index  = random_index();
        ins.left_index  = random_index();
        ins.right_index = random_index();
        ins.load_low    = random_half();
        ins.load_high   = random_half();
        return ins;
    endfunction

    task automatic send_instruction(input vec_instr_t ins, input logic fixed,
                                    input vec_result_t fixed_result);
        vec_result_t predicted;
        while (idle_enabled && $urandom_range(99) < IDLE_PERCENT)
        begin
            instr_bus.valid <= 1'b0;
            @(negedge clk);
        end
        instr_bus.valid       <= 1'b1;
        instr_bus.operation   <= ins.operation;
        instr_bus.lane_size   <= ins.lane_size;
        instr_bus.dest_index  <= ins.dest_index;
        instr_bus.left_index  <= ins.left_index;
        instr_bus.right_index <= ins.right_index;
        instr_bus.load_low    <= ins.load_low;
        instr_bus.load_high   <= ins.load_high;
        do
            @(posedge clk);
        while (!instr_bus.ready);
        predicted = execute_instruction(ins);
        pending_results.push_back(fixed ? fixed_result : predicted);
        @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input vec_result_t want,
                                   input vec_result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%s: expected low=%h high=%h illegal=%b, got low=%h high=%h illegal=%b",
                     what, want.value_low, want.value_high, want.illegal_register,
                     got.value_low, got.value_high, got.illegal_register);
    endtask

    always @(negedge clk)
        result_bus.ready <= !idle_enabled || ($urandom_range(99) >= IDLE_PERCENT);

    always @(posedge clk)
    begin : result_check
        vec_result_t want;
        vec_result_t got;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got = '{result_bus.value_low, result_bus.value_high,
                    result_bus.illegal_register};
            if (pending_results.size() == 0)
                report_mismatch("unexpected result beat", ZERO_RESULT, got);
            else
            begin
                want = pending_results.pop_front();
                if (got.value_low !== want.value_low || got.value_high !== want.value_high
                    || got.illegal_register !== want.illegal_register)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_packed_simd_integer_alu_unit: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int idx;
        cycle_count           = 0;
        mismatch_count        = 0;
        idle_enabled          = 1'b1;
        rst_n                 = 1'b0;
        instr_bus.valid       = 1'b0;
        instr_bus.operation   = '0;
        instr_bus.lane_size   = '0;
        instr_bus.dest_index  = '0;
        instr_bus.left_index  = '0;
        instr_bus.right_index = '0;
        instr_bus.load_low    = '0;
        instr_bus.load_high   = '0;
        result_bus.ready      = 1'b0;
        for (idx = 0; idx < VREG_COUNT; idx++)
        begin
            shadow_low[idx]  = '0;
            shadow_high[idx] = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (idx = 0; idx < DIRECTED_COUNT; idx++)
            send_instruction(DIRECTED_ROWS[idx].instr, DIRECTED_ROWS[idx].fixed,
                             DIRECTED_ROWS[idx].fixed_result);

        for (idx = 0; idx < RANDOM_COUNT; idx++)
        begin
            idle_enabled = !(idx >= STEADY_FIRST && idx < STEADY_LAST);
            send_instruction(random_instruction(), 1'b0, ZERO_RESULT);
        end
        idle_enabled    = 1'b1;
        instr_bus.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_packed_simd_integer_alu_unit: PASS");
        else
            $display("tb_packed_simd_integer_alu_unit: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
